// ===== hdl/srg_pkg.sv =====
// ----------------------------------------------------------------------------
// srg_pkg: shared types and constants of the stepper ramp generator
// Widths, register indexes, phase and sequencer codes, fixed-point helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package srg_pkg;

   // ramp table depth and fixed-point format
   localparam int MAX_STEPS = 256;
   localparam int FRAC_BITS = 8;

   localparam int DELAY_W  = 24;   // running delay, fixed point
   localparam int MIN_W    = 16;   // min_delay register
   localparam int LEN_W    = 9;    // ramp_steps register
   localparam int WHOLE_W  = 16;   // stored / counted delay in ticks
   localparam int CSR_IDX_W = 2;

   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam int ADDR_W = $clog2(MAX_STEPS);

   // divider: dividend 2*d, divisor 4*i+1
   localparam int DVD_W = DELAY_W + 1;
   localparam int DEN_W = STEP_W + 2;
   localparam int DCNT_W = $clog2(DVD_W + 1);

   localparam logic [DELAY_W-1:0] START_DELAY_RST = DELAY_W'(3119754);
   localparam logic [MIN_W-1:0]   MIN_DELAY_RST   = MIN_W'(10);
   localparam logic [LEN_W-1:0]   RAMP_STEPS_RST  = LEN_W'(200);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_DELAY = 2'd0,
      CSR_MIN_DELAY   = 2'd1,
      CSR_RAMP_STEPS  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_ACCEL = 2'd1,
      PH_DECEL = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_DIV  = 2'd1,
      ST_RD   = 2'd2,
      ST_OUT  = 2'd3
   } seq_state_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   // min_delay in fixed point, saturated to the delay width
   function automatic logic [DELAY_W-1:0] floor_fx(input logic [MIN_W-1:0] min_delay);
      logic [47:0] wide;
      wide = 48'(min_delay) << FRAC_BITS;
      if (wide > 48'({DELAY_W{1'b1}}))
         floor_fx = {DELAY_W{1'b1}};
      else
         floor_fx = wide[DELAY_W-1:0];
   endfunction

   // integer part of a delay, saturated to the tick counter width
   function automatic logic [WHOLE_W-1:0] whole_ticks(input logic [DELAY_W-1:0] d);
      logic [DELAY_W-1:0] sh;
      sh = d >> FRAC_BITS;
      if (32'(sh) > 32'({WHOLE_W{1'b1}}))
         whole_ticks = {WHOLE_W{1'b1}};
      else
         whole_ticks = sh[WHOLE_W-1:0];
   endfunction

   // latched ramp length: zero taken as one, saturated to the table depth
   function automatic logic [STEP_W-1:0] ramp_len(input logic [LEN_W-1:0] n);
      if (n == '0)
         ramp_len = STEP_W'(1);
      else if (32'(n) > MAX_STEPS)
         ramp_len = STEP_W'(MAX_STEPS);
      else
         ramp_len = STEP_W'(n);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/srg_ram.sv =====
// ----------------------------------------------------------------------------
// srg_ram: generic single-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/srg_div.sv =====
// ----------------------------------------------------------------------------
// srg_div: bit-serial restoring divider
// One quotient bit per cycle; dividend shifts out as quotient shifts in.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire srg_pkg::div_ctl_type       div_ctl,
   input  wire logic [srg_pkg::DVD_W-1:0]  dividend,
   input  wire logic [srg_pkg::DEN_W-1:0]  divisor,
   output      srg_pkg::div_sts_type       div_sts,
   output      logic [srg_pkg::DVD_W-1:0]  quotient
);
   import srg_pkg::*;

   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           ge;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_ctl.start) begin
         dvd_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = DCNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         dvd_in = {dvd_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_sts.busy = busy_ff;
   assign div_sts.done = done_ff;
   assign quotient     = dvd_ff;

endmodule

`default_nettype wire

// ===== hdl/stepper_accel_ramp_generator.sv =====
// ----------------------------------------------------------------------------
// stepper_accel_ramp_generator: constant-acceleration stepper ramp
// Drives one symmetric move per start request from microsecond ticks.
// ----------------------------------------------------------------------------
// Each req_ transaction carries one tick/start sample and yields exactly one
// rsp_ transaction with the step line, latched direction, busy and done
// flags after that sample. Most transactions pass from acceptance through
// the output state to the result register. The tick that opens a new
// acceleration step runs the recurrence d -= 2d/(4i+1) through a bit-serial
// divider, one quotient bit per cycle over the 25-bit dividend. A tick that
// opens a deceleration step reads the delay table through its registered
// read port. A new request is taken once the previous one has moved to
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_accel_ramp_generator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // item channel
   input  wire logic                           req_valid,
   output      logic                           req_ready,
   input  wire logic                           req_tick,
   input  wire logic                           req_start_req,
   input  wire logic                           req_direction,
   // result channel
   output      logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   output      logic                           rsp_step_level,
   output      logic                           rsp_direction_level,
   output      logic                           rsp_busy_res,
   output      logic                           rsp_move_done,
   // register writes
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [srg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [srg_pkg::DELAY_W-1:0]    csr_data
);
   import srg_pkg::*;

   // ---- configuration registers ----
   logic [DELAY_W-1:0] start_delay_ff, start_delay_in;
   logic [MIN_W-1:0]   min_delay_ff, min_delay_in;
   logic [LEN_W-1:0]   ramp_steps_ff, ramp_steps_in;
   logic               csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      start_delay_in = start_delay_ff;
      min_delay_in   = min_delay_ff;
      ramp_steps_in  = ramp_steps_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_START_DELAY: start_delay_in = csr_data;
            CSR_MIN_DELAY:   min_delay_in   = csr_data[MIN_W-1:0];
            CSR_RAMP_STEPS:  ramp_steps_in  = csr_data[LEN_W-1:0];
            default:         ;   // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_delay_ff <= START_DELAY_RST;
         min_delay_ff   <= MIN_DELAY_RST;
         ramp_steps_ff  <= RAMP_STEPS_RST;
      end else begin
         start_delay_ff <= start_delay_in;
         min_delay_ff   <= min_delay_in;
         ramp_steps_ff  <= ramp_steps_in;
      end
   end

   // ---- move state ----
   seq_state_type      state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [STEP_W-1:0]  len_ff, len_in;
   logic [DELAY_W-1:0] run_ff, run_in;
   logic [WHOLE_W-1:0] cnt_ff, cnt_in;
   logic               dir_ff, dir_in;
   logic               pulse_ff, pulse_in;
   logic               done_ff, done_in;

   // ---- result register ----
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_step_ff, rsp_dir_ff, rsp_busy_ff, rsp_done_ff;

   // ---- item decode ----
   logic              req_fire;
   logic              is_start, is_cnt, is_step;
   logic [STEP_W-1:0] step_next;
   logic              last_step;
   logic              need_div, need_rd, is_finish;

   assign req_fire  = req_valid && req_ready;
   assign is_start  = (phase_ff == PH_IDLE) && req_start_req;
   assign is_cnt    = (phase_ff != PH_IDLE) && req_tick && pulse_ff;
   assign is_step   = (phase_ff != PH_IDLE) && req_tick && !pulse_ff;
   assign step_next = step_ff + STEP_W'(1);
   assign last_step = (step_next >= len_ff);
   assign need_div  = is_step && (phase_ff == PH_ACCEL) && !last_step;
   assign need_rd   = is_step && (((phase_ff == PH_ACCEL) && last_step) ||
                                  ((phase_ff == PH_DECEL) && !last_step));
   assign is_finish = is_step && (phase_ff == PH_DECEL) && last_step;

   // ---- divider ----
   div_ctl_type      div_ctl;
   div_sts_type      div_sts;
   logic [DVD_W-1:0] quotient;
   logic [DEN_W-1:0] divisor;

   assign divisor = {step_next, 2'b01};   // 4*i + 1

   srg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_ctl  (div_ctl),
      .dividend ({run_ff, 1'b0}),
      .divisor  (divisor),
      .div_sts  (div_sts),
      .quotient (quotient)
   );

   // ---- delay table ----
   logic               ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [WHOLE_W-1:0] ram_rd_data;
   logic [STEP_W-1:0]  rd_step, rd_idx;

   // deceleration plays back entry len-1-i
   assign rd_step = (phase_ff == PH_ACCEL) ? '0 : step_next;
   assign rd_idx  = len_ff - STEP_W'(1) - rd_step;
   assign ram_rd_addr = rd_idx[ADDR_W-1:0];
   // start writes entry 0, later accel steps the (already advanced) step
   assign ram_wr_addr = (state_ff == ST_IDLE) ? '0 : step_ff[ADDR_W-1:0];

   // ---- new acceleration delay: clamp and truncate ----
   logic [DELAY_W-1:0] accel_src, accel_floor, accel_delay;
   logic [WHOLE_W-1:0] accel_whole;

   assign accel_src   = (state_ff == ST_IDLE) ? start_delay_ff
                                              : run_ff - quotient[DELAY_W-1:0];
   assign accel_floor = floor_fx(min_delay_ff);
   assign accel_delay = (accel_src < accel_floor) ? accel_floor : accel_src;
   assign accel_whole = whole_ticks(accel_delay);

   srg_ram #(
      .WIDTH (WHOLE_W),
      .DEPTH (MAX_STEPS)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (accel_whole),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---- sequencer: next state ----
   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (need_div)
                  state_in = ST_DIV;
               else if (need_rd)
                  state_in = ST_RD;
               else
                  state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            if (div_sts.done)
               state_in = ST_OUT;
         end
         ST_RD:   state_in = ST_OUT;
         ST_OUT: begin
            if (out_free)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---- sequencer: outputs ----
   logic accel_load, rd_load, out_load, item_take;

   always_comb begin
      req_ready     = 1'b0;
      div_ctl.start = 1'b0;
      accel_load    = 1'b0;
      ram_rd_en     = 1'b0;
      rd_load       = 1'b0;
      out_load      = 1'b0;
      item_take     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            item_take     = req_valid;
            div_ctl.start = req_valid && need_div;
            ram_rd_en     = req_valid && need_rd;
            accel_load    = req_valid && is_start;
         end
         ST_DIV:  accel_load = div_sts.done;
         ST_RD:   rd_load    = 1'b1;
         ST_OUT:  out_load   = out_free;
         default: ;
      endcase
   end

   assign ram_wr_en = accel_load;

   // ---- move datapath ----
   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      len_in   = len_ff;
      run_in   = run_ff;
      cnt_in   = cnt_ff;
      dir_in   = dir_ff;
      pulse_in = pulse_ff;
      done_in  = done_ff;
      if (item_take) begin
         done_in = 1'b0;
         if (is_start) begin
            len_in   = ramp_len(ramp_steps_ff);
            dir_in   = req_direction;
            step_in  = '0;
            phase_in = PH_ACCEL;
         end
         if (is_cnt) begin
            if (cnt_ff <= WHOLE_W'(1)) begin
               cnt_in   = '0;
               pulse_in = 1'b0;
            end else begin
               cnt_in = cnt_ff - WHOLE_W'(1);
            end
         end
         if (is_step) begin
            step_in = last_step ? '0 : step_next;
            if ((phase_ff == PH_ACCEL) && last_step)
               phase_in = PH_DECEL;
            if (is_finish) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end
         end
      end
      if (accel_load) begin
         run_in   = accel_delay;
         cnt_in   = accel_whole;
         pulse_in = 1'b1;
      end
      if (rd_load) begin
         cnt_in   = ram_rd_data;
         pulse_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
         step_ff  <= '0;
         len_ff   <= '0;
         run_ff   <= '0;
         cnt_ff   <= '0;
         dir_ff   <= 1'b0;
         pulse_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
         len_ff   <= len_in;
         run_ff   <= run_in;
         cnt_ff   <= cnt_in;
         dir_ff   <= dir_in;
         pulse_ff <= pulse_in;
         done_ff  <= done_in;
      end
   end

   // ---- result register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
      if (out_load) begin
         rsp_step_ff <= pulse_ff;
         rsp_dir_ff  <= dir_ff;
         rsp_busy_ff <= (phase_ff != PH_IDLE);
         rsp_done_ff <= done_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_step_level      = rsp_step_ff;
   assign rsp_direction_level = rsp_dir_ff;
   assign rsp_busy_res        = rsp_busy_ff;
   assign rsp_move_done       = rsp_done_ff;

   // ---- checks ----
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide state");

   a_div_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && !div_sts.done |-> div_sts.busy)
      else $error("divide state without a running divider");

   a_idle_line_low: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> !pulse_ff)
      else $error("step line high while idle");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> step_ff < len_ff)
      else $error("step index beyond ramp length");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> !rsp_busy_ff)
      else $error("move done reported while busy");

endmodule

`default_nettype wire
